// ===== hw/rtl/rfcc_pkg.sv =====
// rfcc_pkg: shared constants, status codes and the result struct of the
// received-frame crc checker; no dependencies
package rfcc_pkg;

  localparam int MAX_PAYLOAD_BYTES = 256;
  // byte counter saturates a little above the payload bound
  localparam int COUNT_CAP = MAX_PAYLOAD_BYTES + 5;
  localparam int CNT_W     = $clog2(COUNT_CAP + 1);
  localparam int LEN_W     = CNT_W + 1;
  localparam int PLEN_W    = 9;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] ERR_REPORT_CODE_RESET = 16'd18;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CRC_BAD  = 2'd1;
  localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

  typedef struct packed {
    logic [1:0]        frame_status;
    logic [15:0]       return_code;
    logic              is_error_report;
    logic [7:0]        error_code;
    logic [PLEN_W-1:0] payload_length;
    logic [15:0]       computed_crc;
    logic [15:0]       received_crc;
  } rfcc_result_t;

endpackage

// ===== hw/rtl/rfcc_crc_byte.sv =====
// rfcc_crc_byte: one-byte crc-16/ccitt-false update, msb first
// depends on rfcc_pkg
module rfcc_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);
  import rfcc_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ===== hw/rtl/rfcc_frame_state.sv =====
// rfcc_frame_state: per-frame state (crc, header, tail, count) and the
// frame-end result logic; depends on rfcc_pkg and rfcc_crc_byte
module rfcc_frame_state (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  input  logic                  last_byte,
  input  logic [15:0]           err_report_code,
  output rfcc_pkg::rfcc_result_t res
);
  import rfcc_pkg::*;

  logic [15:0]      crc_accum;
  logic [7:0]       tail0, tail1;
  logic [7:0]       hdr0, hdr1, hdr2;
  logic [CNT_W-1:0] byte_count;

  logic [15:0]      crc_fed, crc_cur;
  logic             feed;
  logic [7:0]       h0, h1, h2;
  logic [LEN_W-1:0] len, plen_full;
  logic             too_short, too_long, crc_match;
  logic [15:0]      rc, rx_crc;

  // byte two places back is now known to be payload
  rfcc_crc_byte u_crc (
    .crc_in  (crc_accum),
    .data_in (tail0),
    .crc_out (crc_fed)
  );

  always_comb begin
    feed      = byte_count >= CNT_W'(2);
    crc_cur   = feed ? crc_fed : crc_accum;
    h0        = (byte_count == CNT_W'(0)) ? rx_byte : hdr0;
    h1        = (byte_count == CNT_W'(1)) ? rx_byte : hdr1;
    h2        = (byte_count == CNT_W'(2)) ? rx_byte : hdr2;
    rc        = {h1, h0};
    rx_crc    = {rx_byte, tail1};
    len       = LEN_W'(byte_count) + LEN_W'(1);
    plen_full = len - LEN_W'(4);
    too_short = len < LEN_W'(4);
    too_long  = !too_short && (plen_full > LEN_W'(MAX_PAYLOAD_BYTES));
    crc_match = crc_cur == rx_crc;

    res.return_code     = rc;
    res.computed_crc    = crc_cur;
    res.received_crc    = rx_crc;
    res.is_error_report = !too_short && crc_match && (rc == err_report_code);
    res.error_code      = res.is_error_report ? h2 : 8'h00;
    if (too_short) begin
      res.frame_status   = STATUS_TOO_SHORT;
      res.payload_length = '0;
    end else if (too_long) begin
      res.frame_status   = STATUS_TOO_LONG;
      res.payload_length = PLEN_W'(MAX_PAYLOAD_BYTES);
    end else begin
      res.frame_status   = crc_match ? STATUS_OK : STATUS_CRC_BAD;
      res.payload_length = plen_full[PLEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      crc_accum  <= CRC_INIT;
      tail0      <= '0;
      tail1      <= '0;
      hdr0       <= '0;
      hdr1       <= '0;
      hdr2       <= '0;
      byte_count <= '0;
    end else if (step) begin
      crc_accum <= crc_cur;
      hdr0      <= h0;
      hdr1      <= h1;
      hdr2      <= h2;
      tail0     <= tail1;
      tail1     <= rx_byte;
      if (byte_count < CNT_W'(COUNT_CAP)) begin
        byte_count <= byte_count + CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/rx_frame_crc_checker_core.sv =====
// rx_frame_crc_checker_core: top level of the received-frame crc checker
// depends on rfcc_pkg and rfcc_frame_state
// usage
// - input channel: one frame byte per word (rx_byte, last_byte marks the
//   final byte), moved on in_valid high and in_stall low
// - output channel: one result word per frame, moved on out_valid high
//   and out_stall low; bytes that do not end a frame give no result
// - crc-16/ccitt-false runs over all but the two trailing bytes, which
//   are the received crc, low byte first
// - config: cfg_wr_en writes cfg_wr_data into the error report code;
//   write it only while no frame is in flight
// - result path: a final byte passes the input register, then the result
//   register, before its result shows on the output ports
// - throughput: one byte per cycle while no final byte waits on a stalled
//   output, set by the single byte-wide crc step between the input and result registers
// - reset: frame state clears, crc goes to 0xffff, error report code to 18,
//   both registers empty
// - output stall: non-final bytes keep flowing; a final byte waits in the
//   input register until the result register is free, and meanwhile in_stall
//   holds new bytes off
module rx_frame_crc_checker_core (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  frame_status,
  output logic [15:0] return_code,
  output logic        is_error_report,
  output logic [7:0]  error_code,
  output logic [rfcc_pkg::PLEN_W-1:0] payload_length,
  output logic [15:0] computed_crc,
  output logic [15:0] received_crc
);
  import rfcc_pkg::*;

  logic [15:0]  err_report_code;

  // input register
  logic         in_full;
  logic [7:0]   in_byte;
  logic         in_last;

  logic         out_free;
  logic         step;
  rfcc_result_t res;

  // result register can take a word when empty or draining this cycle
  assign out_free = !out_valid || !out_stall;
  // non-final bytes never need the result register
  assign step     = in_full && (!in_last || out_free);
  assign in_stall = in_full && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      err_report_code <= ERR_REPORT_CODE_RESET;
    end else if (cfg_wr_en) begin
      err_report_code <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
      in_last <= last_byte;
    end
  end

  rfcc_frame_state u_frame (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .rx_byte         (in_byte),
    .last_byte       (in_last),
    .err_report_code (err_report_code),
    .res             (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && in_last) begin
      frame_status    <= res.frame_status;
      return_code     <= res.return_code;
      is_error_report <= res.is_error_report;
      error_code      <= res.error_code;
      payload_length  <= res.payload_length;
      computed_crc    <= res.computed_crc;
      received_crc    <= res.received_crc;
    end
  end

endmodule
